// File: rtl/greedy_note_dispenser_unit_macros.svh
// assertion helpers shared by the dispenser modules
// both expect clk and rst_n in scope
`ifndef GREEDY_NOTE_DISPENSER_UNIT_MACROS_SVH
`define GREEDY_NOTE_DISPENSER_UNIT_MACROS_SVH

// same-cycle implication
`define GND_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define GND_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// File: rtl/gnd_pkg.sv
`default_nettype none

package gnd_pkg;

  // field widths
  localparam int AMT_W  = 20;
  localparam int VAL_W  = 10;
  localparam int PROD_W = 2 * VAL_W;
  localparam int STAT_W = 2;
  localparam int SLOT_IN_W = 3;
  localparam int CFG_IDX_W = 3;

  // number of value registers and output slots
  localparam int NUM_CFG = 6;

  // opcodes
  localparam logic OP_WITHDRAW = 1'b0;
  localparam logic OP_LOAD     = 1'b1;

  // result status codes
  localparam logic [STAT_W-1:0] STAT_DISPENSED = 2'd0;
  localparam logic [STAT_W-1:0] STAT_SHORT     = 2'd1;
  localparam logic [STAT_W-1:0] STAT_LOADED    = 2'd2;

  // reset values per slot
  localparam logic [VAL_W-1:0] VALUE_RST [NUM_CFG] = '{10'd100, 10'd50, 10'd20,
                                                       10'd10, 10'd5, 10'd2};
  localparam logic [VAL_W-1:0] STOCK_RST [NUM_CFG] = '{10'd4, 10'd8, 10'd15,
                                                       10'd20, 10'd5, 10'd10};

  // controller to datapath
  typedef struct packed {
    logic start;
    logic sum_mul;
    logic sum_acc;
    logic check;
    logic div_init;
    logic div_step;
    logic mul;
    logic sub;
    logic fin;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic insufficient;
    logic skip;
  } sts_t;

endpackage

`default_nettype wire

// File: rtl/gnd_ctrl.sv
`default_nettype none
`include "greedy_note_dispenser_unit_macros.svh"

module gnd_ctrl import gnd_pkg::*; #(
  parameter int NUM_DENOMS = 6,
  localparam int SLOT_W = $clog2(NUM_DENOMS)
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire logic              in_opcode,
  output logic                   out_valid,
  input  wire logic              out_ready,
  input  wire sts_t              sts,
  output cmd_t                   cmd,
  output logic [SLOT_W-1:0]      slot_idx
);

  localparam int BIT_W = $clog2(AMT_W);
  localparam logic [BIT_W-1:0]  BIT_LAST = BIT_W'(AMT_W - 1);
  localparam logic [SLOT_W-1:0] IDX_LAST = SLOT_W'(NUM_DENOMS - 1);

  localparam logic [3:0] ST_IDLE    = 4'd0;
  localparam logic [3:0] ST_SUM_MUL = 4'd1;
  localparam logic [3:0] ST_SUM_ACC = 4'd2;
  localparam logic [3:0] ST_CHECK   = 4'd3;
  localparam logic [3:0] ST_SLOT    = 4'd4;
  localparam logic [3:0] ST_DIV     = 4'd5;
  localparam logic [3:0] ST_MUL     = 4'd6;
  localparam logic [3:0] ST_SUB     = 4'd7;
  localparam logic [3:0] ST_FIN     = 4'd8;

  logic [3:0]        state_r, state_nxt;
  logic [SLOT_W-1:0] idx_r, idx_nxt;
  logic [BIT_W-1:0]  bit_r, bit_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic              idx_last;

  assign idx_last  = (idx_r == IDX_LAST);
  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;
  assign slot_idx  = idx_r;

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    idx_nxt       = idx_r;
    bit_nxt       = bit_r;
    cmd           = '0;
    out_valid_nxt = out_valid_r && !out_ready;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.start = 1'b1;
          idx_nxt   = '0;
          state_nxt = (in_opcode == OP_LOAD) ? ST_FIN : ST_SUM_MUL;
        end
      end
      ST_SUM_MUL: begin
        cmd.sum_mul = 1'b1;
        state_nxt   = ST_SUM_ACC;
      end
      ST_SUM_ACC: begin
        cmd.sum_acc = 1'b1;
        if (idx_last) begin
          idx_nxt   = '0;
          state_nxt = ST_CHECK;
        end else begin
          idx_nxt   = idx_r + 1'b1;
          state_nxt = ST_SUM_MUL;
        end
      end
      ST_CHECK: begin
        cmd.check = 1'b1;
        state_nxt = sts.insufficient ? ST_FIN : ST_SLOT;
      end
      ST_SLOT: begin
        if (sts.skip) begin
          if (idx_last) begin
            state_nxt = ST_FIN;
          end else begin
            idx_nxt = idx_r + 1'b1;
          end
        end else begin
          cmd.div_init = 1'b1;
          bit_nxt      = '0;
          state_nxt    = ST_DIV;
        end
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        if (bit_r == BIT_LAST) begin
          state_nxt = ST_MUL;
        end else begin
          bit_nxt = bit_r + 1'b1;
        end
      end
      ST_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = ST_SUB;
      end
      ST_SUB: begin
        cmd.sub = 1'b1;
        if (idx_last) begin
          state_nxt = ST_FIN;
        end else begin
          idx_nxt   = idx_r + 1'b1;
          state_nxt = ST_SLOT;
        end
      end
      ST_FIN: begin
        if (!out_valid_r || out_ready) begin
          cmd.fin       = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      idx_r       <= '0;
      bit_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      idx_r       <= idx_nxt;
      bit_r       <= bit_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  `GND_ASSERT_NEXT(a_accept_leaves_idle, in_valid && in_ready, state_r != ST_IDLE, "accepted beat left controller idle")
  `GND_ASSERT_IMPL(a_no_overwrite, cmd.fin, !out_valid_r || out_ready, "result overwrote a pending beat")
  `GND_ASSERT_NEXT(a_fin_shows_result, cmd.fin, out_valid_r, "finished item produced no result beat")

endmodule

`default_nettype wire

// File: rtl/gnd_dpath.sv
`default_nettype none
`include "greedy_note_dispenser_unit_macros.svh"

module gnd_dpath import gnd_pkg::*; #(
  parameter int NUM_DENOMS = 6,
  localparam int SLOT_W = $clog2(NUM_DENOMS)
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [VAL_W-1:0]     cfg_data,
  input  wire logic                 in_opcode,
  input  wire logic [AMT_W-1:0]     in_amount,
  input  wire logic [SLOT_IN_W-1:0] in_slot,
  input  wire logic [VAL_W-1:0]     in_count,
  input  wire cmd_t                 cmd,
  input  wire logic [SLOT_W-1:0]    slot_idx,
  output sts_t                      sts,
  output logic [STAT_W-1:0]         out_status,
  output logic [VAL_W-1:0]          out_given [NUM_CFG],
  output logic [AMT_W-1:0]          out_remainder
);

  // running total: each product below 2^PROD_W, at most 2^SLOT_W of them
  localparam int TOT_W = PROD_W + SLOT_W;

  logic [VAL_W-1:0]  value_r [NUM_DENOMS];
  logic [VAL_W-1:0]  stock_r [NUM_DENOMS];
  logic [VAL_W-1:0]  given_r [NUM_DENOMS];
  logic              op_r;
  logic              insuf_r;
  logic [AMT_W-1:0]  rest_r;
  logic [TOT_W-1:0]  acc_r;
  logic [PROD_W-1:0] prod_r;
  logic [AMT_W-1:0]  quo_r;
  logic [VAL_W-1:0]  rem_r;
  logic [VAL_W-1:0]  n_r;
  logic [PROD_W-1:0] nv_r;
  logic [STAT_W-1:0] out_status_r;
  logic [VAL_W-1:0]  out_given_r [NUM_CFG];
  logic [AMT_W-1:0]  out_rem_r;

  logic [VAL_W-1:0]  v_sel;
  logic [VAL_W-1:0]  s_sel;
  logic [VAL_W:0]    trial;
  logic              q_bit;
  logic [VAL_W-1:0]  n_min;

  assign v_sel = value_r[slot_idx];
  assign s_sel = stock_r[slot_idx];

  // status toward the controller
  assign sts.insufficient = (TOT_W'(rest_r) > acc_r);
  assign sts.skip = (v_sel == '0) || (s_sel == '0) || (rest_r < AMT_W'(v_sel));

  // one restoring divide step
  assign trial = {rem_r, quo_r[AMT_W-1]};
  assign q_bit = (trial >= {1'b0, v_sel});

  // notes taken are capped by the stock
  assign n_min = (quo_r > AMT_W'(s_sel)) ? s_sel : quo_r[VAL_W-1:0];

  // per-slot value, stock and given registers
  for (genvar i = 0; i < NUM_DENOMS; i++) begin : g_slot
    if (i < NUM_CFG) begin : g_cfg
      always_ff @(posedge clk) begin
        if (!rst_n) begin
          value_r[i] <= VALUE_RST[i];
        end else if (cfg_we && (int'(cfg_index) == i)) begin
          value_r[i] <= cfg_data;
        end
      end
    end else begin : g_fixed
      always_ff @(posedge clk) begin
        if (!rst_n) begin
          value_r[i] <= VAL_W'(1);
        end
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        stock_r[i] <= (i < NUM_CFG) ? STOCK_RST[i % NUM_CFG] : '0;
      end else if (cmd.start && (in_opcode == OP_LOAD) && (int'(in_slot) == i)) begin
        stock_r[i] <= in_count;
      end else if (cmd.sub && (slot_idx == SLOT_W'(i))) begin
        stock_r[i] <= stock_r[i] - n_r;
      end
    end

    always_ff @(posedge clk) begin
      if (cmd.start) begin
        given_r[i] <= '0;
      end else if (cmd.sub && (slot_idx == SLOT_W'(i))) begin
        given_r[i] <= n_r;
      end
    end
  end

  // item registers, total, divider and multiply-subtract
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      op_r    <= in_opcode;
      insuf_r <= 1'b0;
      rest_r  <= (in_opcode == OP_LOAD) ? '0 : in_amount;
      acc_r   <= '0;
    end
    if (cmd.sum_mul) begin
      prod_r <= PROD_W'(v_sel) * PROD_W'(s_sel);
    end
    if (cmd.sum_acc) begin
      acc_r <= acc_r + TOT_W'(prod_r);
    end
    if (cmd.check) begin
      insuf_r <= sts.insufficient;
    end
    if (cmd.div_init) begin
      quo_r <= rest_r;
      rem_r <= '0;
    end
    if (cmd.div_step) begin
      quo_r <= {quo_r[AMT_W-2:0], q_bit};
      rem_r <= q_bit ? VAL_W'(trial - {1'b0, v_sel}) : trial[VAL_W-1:0];
    end
    if (cmd.mul) begin
      n_r  <= n_min;
      nv_r <= PROD_W'(n_min) * PROD_W'(v_sel);
    end
    if (cmd.sub) begin
      rest_r <= rest_r - AMT_W'(nv_r);
    end
  end

  // result beat payload
  always_ff @(posedge clk) begin
    if (cmd.fin) begin
      out_status_r <= (op_r == OP_LOAD) ? STAT_LOADED :
                      (insuf_r ? STAT_SHORT : STAT_DISPENSED);
      out_rem_r    <= rest_r;
    end
  end

  for (genvar k = 0; k < NUM_CFG; k++) begin : g_out
    always_ff @(posedge clk) begin
      if (cmd.fin) begin
        out_given_r[k] <= (k < NUM_DENOMS) ? given_r[k % NUM_DENOMS] : '0;
      end
    end
    assign out_given[k] = out_given_r[k];
  end

  assign out_status    = out_status_r;
  assign out_remainder = out_rem_r;

  `GND_ASSERT_IMPL(a_no_underflow, cmd.sub, n_r <= s_sel, "notes taken exceed slot stock")
  `GND_ASSERT_NEXT(a_rest_shrinks, cmd.sub, rest_r <= $past(rest_r), "remaining amount grew")
  `GND_ASSERT_IMPL(a_div_rem_bound, cmd.div_step, rem_r < v_sel, "divider remainder out of range")

endmodule

`default_nettype wire

// File: rtl/greedy_note_dispenser_unit.sv
// Cash dispenser with NUM_DENOMS note slots, each with a face value and a stock.
// Input channel (in_valid/in_ready): opcode 0 withdraws in_amount, opcode 1
// loads in_count notes into slot in_slot. Every input beat gives exactly one
// result beat on the output channel (out_valid/out_ready): status, notes
// given per slot and the undispensed remainder.
// Face values are written on the cfg port (cfg_we, cfg_index, cfg_data),
// taking effect at once; write them only while the block is idle.
// A load goes from acceptance straight to the final state. A withdraw first
// sums value*stock over the slots (a multiply, then an accumulate, per slot);
// if the total falls short it goes straight to its final state, otherwise it
// visits each slot: an empty or unusable slot is skipped, otherwise a radix-2
// restoring divider runs, then a multiply-subtract; the divider sets the pace.
// One item is in flight at a time; in_ready is high only while idle.
// The result sits in an output register, so the next item is accepted while
// it waits; if the receiver still stalls when that item finishes, the block
// holds in its final state until the pending beat is taken.
// Reset (rst_n, synchronous) restores values 100,50,20,10,5,2 and stock
// 4,8,15,20,5,10, and drops any pending result.
`default_nettype none

module greedy_note_dispenser_unit import gnd_pkg::*; #(
  parameter int NUM_DENOMS = 6
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [VAL_W-1:0]     cfg_data,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire logic                 in_opcode,
  input  wire logic [AMT_W-1:0]     in_amount,
  input  wire logic [SLOT_IN_W-1:0] in_slot,
  input  wire logic [VAL_W-1:0]     in_count,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output logic [STAT_W-1:0]         out_status,
  output logic [VAL_W-1:0]          out_given_0,
  output logic [VAL_W-1:0]          out_given_1,
  output logic [VAL_W-1:0]          out_given_2,
  output logic [VAL_W-1:0]          out_given_3,
  output logic [VAL_W-1:0]          out_given_4,
  output logic [VAL_W-1:0]          out_given_5,
  output logic [AMT_W-1:0]          out_remainder
);

  localparam int SLOT_W = $clog2(NUM_DENOMS);

  cmd_t              cmd;
  sts_t              sts;
  logic [SLOT_W-1:0] slot_idx;
  logic [VAL_W-1:0]  given [NUM_CFG];

  // sequencer
  gnd_ctrl #(
    .NUM_DENOMS (NUM_DENOMS)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_opcode (in_opcode),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd),
    .slot_idx  (slot_idx)
  );

  // slot state, divider and result registers
  gnd_dpath #(
    .NUM_DENOMS (NUM_DENOMS)
  ) u_dpath (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .in_opcode     (in_opcode),
    .in_amount     (in_amount),
    .in_slot       (in_slot),
    .in_count      (in_count),
    .cmd           (cmd),
    .slot_idx      (slot_idx),
    .sts           (sts),
    .out_status    (out_status),
    .out_given     (given),
    .out_remainder (out_remainder)
  );

  // per-slot result fields
  assign out_given_0 = given[0];
  assign out_given_1 = given[1];
  assign out_given_2 = given[2];
  assign out_given_3 = given[3];
  assign out_given_4 = given[4];
  assign out_given_5 = given[5];

endmodule

`default_nettype wire

// File: tb/tb_top.sv
module tb_top import gnd_pkg::*; ();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int HALF_PERIOD = 10;
  localparam int RESET_CYCLES = 12;
  localparam int QUIET_LIMIT = 3000;
  localparam int TAIL_CYCLES = 200;
  localparam int PHASE_ITEMS = 450;
  localparam logic [AMT_W-1:0] AMT_MAX = '1;

  typedef logic [VAL_W-1:0] value_set_t [NUM_CFG];

  // one result beat as the block should report it
  typedef struct packed {
    logic [STAT_W-1:0]              status;
    logic [NUM_CFG-1:0][VAL_W-1:0]  given;
    logic [AMT_W-1:0]               remainder;
  } payout_t;

  localparam value_set_t RESET_VALUES = '{10'd100, 10'd50, 10'd20, 10'd10, 10'd5, 10'd2};
  localparam value_set_t RESET_STOCK  = '{10'd4, 10'd8, 10'd15, 10'd20, 10'd5, 10'd10};

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [VAL_W-1:0]     cfg_data = '0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic                 in_opcode = OP_WITHDRAW;
  logic [AMT_W-1:0]     in_amount = '0;
  logic [SLOT_IN_W-1:0] in_slot = '0;
  logic [VAL_W-1:0]     in_count = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic [STAT_W-1:0]    out_status;
  logic [VAL_W-1:0]     out_given_0, out_given_1, out_given_2;
  logic [VAL_W-1:0]     out_given_3, out_given_4, out_given_5;
  logic [AMT_W-1:0]     out_remainder;
  logic [NUM_CFG-1:0][VAL_W-1:0] seen_given;

  // predictor state
  value_set_t face_value = RESET_VALUES;
  value_set_t note_stock = RESET_STOCK;
  payout_t    owed_payouts [$];
  int         mismatch_count = 0;
  int         sender_idle_pct = 0;
  int         receiver_stall_pct = 0;

  assign seen_given = {out_given_5, out_given_4, out_given_3,
                       out_given_2, out_given_1, out_given_0};

  greedy_note_dispenser_unit i_dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_opcode     (in_opcode),
    .in_amount     (in_amount),
    .in_slot       (in_slot),
    .in_count      (in_count),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_status    (out_status),
    .out_given_0   (out_given_0),
    .out_given_1   (out_given_1),
    .out_given_2   (out_given_2),
    .out_given_3   (out_given_3),
    .out_given_4   (out_given_4),
    .out_given_5   (out_given_5),
    .out_remainder (out_remainder)
  );

  always #(HALF_PERIOD) clk = ~clk;

  // total cash held across all slots
  function automatic longint unsigned cash_on_hand();
    longint unsigned sum;
    sum = 0;
    for (int i = 0; i < NUM_CFG; i++) begin
      sum += longint'(face_value[i]) * longint'(note_stock[i]);
    end
    return sum;
  endfunction

  // cash on hand, clipped to what the amount field can ask for
  function automatic logic [AMT_W-1:0] reachable_amount();
    longint unsigned held;
    held = cash_on_hand();
    return (held > AMT_MAX) ? AMT_MAX : held[AMT_W-1:0];
  endfunction

  // greedy payout over the slots or a restock, updates the stock copy
  function automatic payout_t settle_request(logic op, logic [AMT_W-1:0] amt,
                                             logic [SLOT_IN_W-1:0] slot,
                                             logic [VAL_W-1:0] cnt);
    payout_t     r;
    int unsigned rest;
    int unsigned quo;
    r = '0;
    if (op == OP_LOAD) begin
      if (slot < NUM_CFG) note_stock[slot] = cnt;
      r.status = STAT_LOADED;
    end else if (longint'(amt) > cash_on_hand()) begin
      r.status = STAT_SHORT;
      r.remainder = amt;
    end else begin
      rest = amt;
      for (int i = 0; i < NUM_CFG; i++) begin
        if (face_value[i] != 0 && rest >= face_value[i] && note_stock[i] != 0) begin
          quo = rest / face_value[i];
          if (quo > note_stock[i]) quo = note_stock[i];
          rest -= quo * face_value[i];
          note_stock[i] -= quo[VAL_W-1:0];
          r.given[i] = quo[VAL_W-1:0];
        end
      end
      r.status = STAT_DISPENSED;
      r.remainder = rest[AMT_W-1:0];
    end
    return r;
  endfunction

  // send one beat, record its expected payout on acceptance
  task automatic send_request(input logic op, input logic [AMT_W-1:0] amt,
                              input logic [SLOT_IN_W-1:0] slot,
                              input logic [VAL_W-1:0] cnt);
    int gap;
    if ($urandom_range(0, 99) < sender_idle_pct) begin
      gap = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 200) : $urandom_range(1, 40);
      repeat (gap) begin
        in_valid <= 1'b0;
        @(posedge clk);
      end
    end
    in_valid  <= 1'b1;
    in_opcode <= op;
    in_amount <= amt;
    in_slot   <= slot;
    in_count  <= cnt;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    owed_payouts.push_back(settle_request(op, amt, slot, cnt));
  endtask

  // stop sending and let every pending payout arrive
  task automatic wait_for_quiet();
    in_valid <= 1'b0;
    @(posedge clk);
    while (owed_payouts.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  // write all face values, optionally poke the unused indexes too
  task automatic program_values(input value_set_t vals, input bit poke_unused);
    for (int i = 0; i < NUM_CFG; i++) begin
      cfg_we    <= 1'b1;
      cfg_index <= i[CFG_IDX_W-1:0];
      cfg_data  <= vals[i];
      @(posedge clk);
      face_value[i] = vals[i];
    end
    if (poke_unused) begin
      for (int j = NUM_CFG; j < (1 << CFG_IDX_W); j++) begin
        cfg_we    <= 1'b1;
        cfg_index <= j[CFG_IDX_W-1:0];
        cfg_data  <= VAL_W'($urandom());
        @(posedge clk);
      end
    end
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  function automatic value_set_t random_values(int unsigned top);
    value_set_t v;
    for (int i = 0; i < NUM_CFG; i++) begin
      v[i] = ($urandom_range(0, 11) == 0) ? '0 : VAL_W'($urandom_range(1, top));
    end
    return v;
  endfunction

  // one random beat: mostly payable withdrawals and restocks, some overdraws
  task automatic send_random_request();
    int unsigned pick;
    logic [AMT_W-1:0] amt;
    logic [VAL_W-1:0] cnt;
    pick = $urandom_range(0, 99);
    if (pick < 30) begin
      case ($urandom_range(0, 9))
        0:       cnt = ($urandom_range(0, 1) == 0) ? '0 : '1;
        1, 2, 3: cnt = VAL_W'($urandom());
        default: cnt = VAL_W'($urandom_range(0, 40));
      endcase
      send_request(OP_LOAD, AMT_W'($urandom()), SLOT_IN_W'($urandom_range(0, 7)), cnt);
    end else begin
      if (pick < 85) begin
        amt = ($urandom_range(0, 15) == 0) ? reachable_amount()
                                           : AMT_W'($urandom_range(0, reachable_amount()));
      end else if (pick < 92) begin
        amt = AMT_W'($urandom());
      end else begin
        amt = (reachable_amount() == AMT_MAX) ? AMT_MAX : reachable_amount() + 1'b1;
      end
      send_request(OP_WITHDRAW, amt, SLOT_IN_W'($urandom()), VAL_W'($urandom()));
    end
  endtask

  // reset face values: zero amount, odd leftover, overdraw, empty-out, restocks
  task automatic test_reset_values();
    program_values(RESET_VALUES, 1'b1);
    send_request(OP_WITHDRAW, '0, '0, '0);
    send_request(OP_WITHDRAW, 20'd1, '0, '0);
    send_request(OP_WITHDRAW, 20'd388, '1, '1);
    send_request(OP_WITHDRAW, AMT_MAX, '0, '0);
    send_request(OP_LOAD, '0, 3'd7, '1);
    send_request(OP_LOAD, AMT_MAX, 3'd6, '0);
    send_request(OP_WITHDRAW, reachable_amount(), '0, '0);
    send_request(OP_WITHDRAW, 20'd2, '0, '0);
    for (int i = 0; i < NUM_CFG; i++) begin
      send_request(OP_LOAD, '0, i[SLOT_IN_W-1:0], (i % 2 == 1) ? 10'd1 : '1);
    end
    wait_for_quiet();
  endtask

  // largest and smallest face values, then slots with zero face value
  task automatic test_value_extremes();
    program_values('{10'd1023, 10'd1023, 10'd512, 10'd1, 10'd1, 10'd1}, 1'b1);
    send_request(OP_WITHDRAW, AMT_MAX, '0, '0);
    send_request(OP_WITHDRAW, reachable_amount(), '0, '0);
    wait_for_quiet();
    program_values('{10'd0, 10'd7, 10'd0, 10'd3, 10'd1, 10'd0}, 1'b0);
    send_request(OP_LOAD, '0, 3'd0, 10'd9);
    send_request(OP_LOAD, '0, 3'd1, 10'd5);
    send_request(OP_LOAD, '0, 3'd3, 10'd5);
    send_request(OP_WITHDRAW, 20'd40, '0, '0);
    send_request(OP_WITHDRAW, 20'd1, '0, '0);
    wait_for_quiet();
  endtask

  // random traffic under one value setting and one idling mode
  task automatic run_random_phase(input value_set_t vals, input int idle_pct,
                                  input int stall_pct);
    program_values(vals, 1'b1);
    sender_idle_pct = idle_pct;
    receiver_stall_pct = stall_pct;
    for (int k = 0; k < PHASE_ITEMS; k++) begin
      // hold off once mid-phase until the block has drained
      if (k == PHASE_ITEMS / 2) wait_for_quiet();
      send_random_request();
    end
    wait_for_quiet();
    sender_idle_pct = 0;
    receiver_stall_pct = 0;
  endtask

  task automatic test_random_traffic();
    run_random_phase(RESET_VALUES, 0, 0);
    run_random_phase(random_values(60), 65, 0);
    run_random_phase(random_values(1023), 0, 65);
    run_random_phase(random_values(200), 34, 34);
  endtask

  // main sequence
  initial begin
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_values();
    test_value_extremes();
    test_random_traffic();
    wait_for_quiet();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // receiver back-pressure
  always @(posedge clk) begin
    out_ready <= ($urandom_range(0, 99) >= receiver_stall_pct);
  end

  // compare each result beat against the oldest pending payout
  always @(posedge clk) begin : check_payouts
    payout_t want;
    if (rst_n && out_valid && out_ready) begin
      if (owed_payouts.size() == 0) begin
        $error("result beat with no pending payout");
        mismatch_count++;
      end else begin
        want = owed_payouts.pop_front();
        if (out_status !== want.status) begin
          $error("status expected %0d got %0d", want.status, out_status);
          mismatch_count++;
        end
        for (int i = 0; i < NUM_CFG; i++) begin
          if (seen_given[i] !== want.given[i]) begin
            $error("given_%0d expected %0d got %0d", i, want.given[i], seen_given[i]);
            mismatch_count++;
          end
        end
        if (out_remainder !== want.remainder) begin
          $error("remainder expected %0d got %0d", want.remainder, out_remainder);
          mismatch_count++;
        end
      end
    end
  end

  // watchdog on cycles with no beat on either channel
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready)) quiet = 0;
      else quiet++;
    end
    $display("== FAIL ==");
    $finish;
  end

endmodule
